// ===== hw/rtl/dbrt_pkg.sv =====
// Shared types and constants for the draw batch range tracker.
package dbrt_pkg;

  localparam int TEX_W     = 16;
  localparam int CNT_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TEX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIPE_READY  = 1'd1;

  localparam logic KIND_GRANT = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  typedef enum logic [1:0] {
    REQ_BEGIN   = 2'd0,
    REQ_SET_TEX = 2'd1,
    REQ_PUSH    = 2'd2,
    REQ_FLUSH   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_CHECK = 2'd2,
    ST_LAST  = 2'd3
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_go;
    logic len_nz;
    logic pend_valid;
    logic idx_last;
  } sts_t;

endpackage

// ===== hw/rtl/dbrt_ctrl.sv =====
// Controller: item acceptance and the flush walk over the range table.
module dbrt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dbrt_pkg::sts_t  sts,
  output dbrt_pkg::cmd_t  cmd
);

  dbrt_pkg::state_t state;
  dbrt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.step      = 1'b0;
    cmd.emit_last = 1'b0;
    case (state)
      dbrt_pkg::ST_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && sts.walk_go) begin
          state_next = dbrt_pkg::ST_READ;
        end
      end
      dbrt_pkg::ST_READ: begin
        state_next = dbrt_pkg::ST_CHECK;
      end
      dbrt_pkg::ST_CHECK: begin
        // hold while a pending record must leave and the output is busy
        if (!(sts.len_nz && sts.pend_valid && !sts.out_free)) begin
          cmd.step   = 1'b1;
          state_next = sts.idx_last ? dbrt_pkg::ST_LAST : dbrt_pkg::ST_READ;
        end
      end
      dbrt_pkg::ST_LAST: begin
        if (!sts.pend_valid) begin
          state_next = dbrt_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_next    = dbrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dbrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dbrt_dp.sv =====
// Datapath: counters, range table memories, pending record and output register.
module dbrt_dp #(
  parameter int MAX_RANGES   = 32,
  parameter int MAX_VERTICES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [1:0]                      req_type,
  input  logic [dbrt_pkg::TEX_W-1:0]      texture_handle,
  input  logic                            cfg_we,
  input  logic [dbrt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dbrt_pkg::TEX_W-1:0]      cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            result_kind,
  output logic [dbrt_pkg::TEX_W-1:0]      draw_texture,
  output logic [dbrt_pkg::CNT_W-1:0]      first_vertex,
  output logic [dbrt_pkg::CNT_W-1:0]      vertex_total,
  output logic                            last_result,
  input  dbrt_pkg::cmd_t                  cmd,
  output dbrt_pkg::sts_t                  sts
);

  localparam int TW = dbrt_pkg::TEX_W;
  localparam int CW = dbrt_pkg::CNT_W;
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int FW = $clog2(MAX_RANGES + 1);
  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  // config
  logic [TW-1:0] default_texture;
  logic          pipeline_ready;

  // tracker state
  logic [VW-1:0] vertex_fill, vertex_fill_next;
  logic [FW-1:0] range_fill, range_fill_next;
  logic          range_is_open, range_is_open_next;
  logic [TW-1:0] current_texture, current_texture_next;
  logic [VW-1:0] open_start, open_start_next;
  logic [FW-1:0] walk_idx, walk_idx_next;

  // pending draw record during the walk
  logic          pend_valid, pend_valid_next;
  logic [TW-1:0] pend_texture, pend_texture_next;
  logic [CW-1:0] pend_first, pend_first_next;
  logic [CW-1:0] pend_total, pend_total_next;

  // range table: texture and start at open, length at close
  logic [TW+CW-1:0] ts_mem [MAX_RANGES];
  logic [CW-1:0]    len_mem [MAX_RANGES];
  logic [TW+CW-1:0] rd_ts;
  logic [CW-1:0]    rd_len;
  logic             ts_we, len_we;
  logic [TW+CW-1:0] ts_wdata;

  // output register load
  logic          out_load;
  logic          ld_kind, ld_last;
  logic [TW-1:0] ld_texture;
  logic [CW-1:0] ld_first, ld_total;

  dbrt_pkg::req_t req;
  logic [FW-1:0]  rf_last;
  logic [CW-1:0]  open_len;
  logic           range_full;
  logic [TW-1:0]  push_tex;
  logic [TW-1:0]  rd_tex_sub;

  assign req        = dbrt_pkg::req_t'(req_type);
  assign rf_last    = range_fill - FW'(1);
  assign open_len   = CW'(vertex_fill - open_start);
  assign range_full = (range_fill == FW'(MAX_RANGES));
  assign push_tex   = (current_texture != '0) ? current_texture : default_texture;
  assign rd_tex_sub = (rd_ts[TW+CW-1:CW] != '0) ? rd_ts[TW+CW-1:CW] : default_texture;

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.walk_go    = (req == dbrt_pkg::REQ_FLUSH) && pipeline_ready &&
                          (vertex_fill != '0) && (range_fill != '0);
  assign sts.len_nz     = (rd_len != '0);
  assign sts.pend_valid = pend_valid;
  assign sts.idx_last   = (walk_idx == rf_last);

  always_comb begin
    vertex_fill_next     = vertex_fill;
    range_fill_next      = range_fill;
    range_is_open_next   = range_is_open;
    current_texture_next = current_texture;
    open_start_next      = open_start;
    walk_idx_next        = walk_idx;
    pend_valid_next      = pend_valid;
    pend_texture_next    = pend_texture;
    pend_first_next      = pend_first;
    pend_total_next      = pend_total;
    ts_we                = 1'b0;
    len_we               = 1'b0;
    ts_wdata             = {texture_handle, CW'(vertex_fill)};
    out_load             = 1'b0;
    ld_kind              = dbrt_pkg::KIND_DRAW;
    ld_texture           = pend_texture;
    ld_first             = pend_first;
    ld_total             = pend_total;
    ld_last              = 1'b0;

    if (cmd.accept) begin
      walk_idx_next = '0;
      case (req)
        dbrt_pkg::REQ_BEGIN: begin
          vertex_fill_next     = '0;
          range_fill_next      = '0;
          range_is_open_next   = 1'b0;
          current_texture_next = default_texture;
        end
        dbrt_pkg::REQ_SET_TEX: begin
          if (!range_is_open) begin
            current_texture_next = texture_handle;
          end else if (texture_handle != current_texture) begin
            // close the open range, then open a new one if the table has room
            len_we             = 1'b1;
            range_is_open_next = 1'b0;
            if (!range_full) begin
              ts_we                = 1'b1;
              ts_wdata             = {texture_handle, CW'(vertex_fill)};
              open_start_next      = vertex_fill;
              range_fill_next      = range_fill + FW'(1);
              current_texture_next = texture_handle;
              range_is_open_next   = 1'b1;
            end
          end
        end
        dbrt_pkg::REQ_PUSH: begin
          if (vertex_fill != VW'(MAX_VERTICES)) begin
            if (!range_is_open && !range_full) begin
              ts_we                = 1'b1;
              ts_wdata             = {push_tex, CW'(vertex_fill)};
              open_start_next      = vertex_fill;
              range_fill_next      = range_fill + FW'(1);
              current_texture_next = push_tex;
              range_is_open_next   = 1'b1;
            end
            out_load         = 1'b1;
            ld_kind          = dbrt_pkg::KIND_GRANT;
            ld_texture       = '0;
            ld_first         = CW'(vertex_fill);
            ld_total         = '0;
            ld_last          = 1'b1;
            vertex_fill_next = vertex_fill + VW'(1);
          end
        end
        dbrt_pkg::REQ_FLUSH: begin
          if (pipeline_ready && (vertex_fill != '0)) begin
            if (range_is_open) begin
              len_we             = 1'b1;
              range_is_open_next = 1'b0;
            end
            // no ranges: one draw over the whole buffer
            if (range_fill == '0) begin
              out_load   = 1'b1;
              ld_texture = default_texture;
              ld_first   = '0;
              ld_total   = CW'(vertex_fill);
              ld_last    = 1'b1;
            end
          end
        end
        default: begin
          walk_idx_next = '0;
        end
      endcase
    end

    if (cmd.step) begin
      if (rd_len != '0) begin
        // release the previous record, hold this one until the next is known
        out_load          = pend_valid;
        pend_valid_next   = 1'b1;
        pend_texture_next = rd_tex_sub;
        pend_first_next   = rd_ts[CW-1:0];
        pend_total_next   = rd_len;
      end
      walk_idx_next = walk_idx + FW'(1);
    end

    if (cmd.emit_last) begin
      out_load        = 1'b1;
      ld_last         = 1'b1;
      pend_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_texture <= '0;
      pipeline_ready  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == dbrt_pkg::REG_DEFAULT_TEX) begin
        default_texture <= cfg_data;
      end else if (cfg_idx == dbrt_pkg::REG_PIPE_READY) begin
        pipeline_ready <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_fill     <= '0;
      range_fill      <= '0;
      range_is_open   <= 1'b0;
      current_texture <= '0;
      walk_idx        <= '0;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      vertex_fill     <= vertex_fill_next;
      range_fill      <= range_fill_next;
      range_is_open   <= range_is_open_next;
      current_texture <= current_texture_next;
      walk_idx        <= walk_idx_next;
      pend_valid      <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    open_start   <= open_start_next;
    pend_texture <= pend_texture_next;
    pend_first   <= pend_first_next;
    pend_total   <= pend_total_next;
    if (out_load) begin
      result_kind  <= ld_kind;
      draw_texture <= ld_texture;
      first_vertex <= ld_first;
      vertex_total <= ld_total;
      last_result  <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (ts_we) begin
      ts_mem[range_fill[AW-1:0]] <= ts_wdata;
    end
    if (len_we) begin
      len_mem[rf_last[AW-1:0]] <= open_len;
    end
    rd_ts  <= ts_mem[walk_idx[AW-1:0]];
    rd_len <= len_mem[walk_idx[AW-1:0]];
  end

endmodule

// ===== hw/rtl/draw_batch_range_tracker_top.sv =====
// Top level of the draw batch range tracker.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_ready  | req_type, texture_handle
//   out      | out_valid / out_ready| result_kind, draw_texture, first_vertex,
//            |                      | vertex_total, last_result
//   cfg      | cfg_we               | cfg_idx, cfg_data
//
// Begin, set-texture and push complete on acceptance; a beat can enter every cycle while the
// output is free and no flush walk runs. A flush that walks the ranges goes through a read
// state and a check state per entry, then a last state: the range table has one read port and
// each entry costs a registered read plus a check. Any other flush completes on acceptance.
// Output stalls hold the walk; the next item waits until the output is free.
// Reset is synchronous; the range table has no clearing pass.
module draw_batch_range_tracker_top #(
  parameter int MAX_RANGES   = 32,
  parameter int MAX_VERTICES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [dbrt_pkg::TEX_W-1:0]      texture_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_kind,
  output logic [dbrt_pkg::TEX_W-1:0]      draw_texture,
  output logic [dbrt_pkg::CNT_W-1:0]      first_vertex,
  output logic [dbrt_pkg::CNT_W-1:0]      vertex_total,
  output logic                            last_result,
  input  logic                            cfg_we,
  input  logic [dbrt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dbrt_pkg::TEX_W-1:0]      cfg_data
);

  dbrt_pkg::cmd_t cmd;
  dbrt_pkg::sts_t sts;

  dbrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dbrt_dp #(
    .MAX_RANGES   (MAX_RANGES),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req_type),
    .texture_handle (texture_handle),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .result_kind    (result_kind),
    .draw_texture   (draw_texture),
    .first_vertex   (first_vertex),
    .vertex_total   (vertex_total),
    .last_result    (last_result),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the draw batch range tracker: directed table, then random batches.
module testbench;

  localparam int MAX_RANGES   = 32;
  localparam int MAX_VERTICES = 4096;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 400;
  localparam int TW           = dbrt_pkg::TEX_W;
  localparam int CW           = dbrt_pkg::CNT_W;
  localparam int IW           = dbrt_pkg::CFG_IDX_W;

  typedef struct packed {
    logic          kind;
    logic [TW-1:0] tex;
    logic [CW-1:0] first;
    logic [CW-1:0] total;
    logic          last;
  } result_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_t;
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    dbrt_pkg::req_t  req;
    logic [IW-1:0]   reg_idx;
    logic [TW-1:0]   data;
    check_t          chk;
    result_t         exp;
  } row_t;

  logic          clk            = 1'b0;
  logic          rst            = 1'b1;
  logic          in_valid       = 1'b0;
  logic          in_ready;
  logic [1:0]    req_type       = dbrt_pkg::REQ_BEGIN;
  logic [TW-1:0] texture_handle = '0;
  logic          out_valid;
  logic          out_ready      = 1'b0;
  logic          result_kind;
  logic [TW-1:0] draw_texture;
  logic [CW-1:0] first_vertex;
  logic [CW-1:0] vertex_total;
  logic          last_result;
  logic          cfg_we         = 1'b0;
  logic [IW-1:0] cfg_idx        = dbrt_pkg::REG_DEFAULT_TEX;
  logic [TW-1:0] cfg_data       = '0;

  always #5 clk = ~clk;

  draw_batch_range_tracker_top #(
    .MAX_RANGES  (MAX_RANGES),
    .MAX_VERTICES(MAX_VERTICES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .texture_handle(texture_handle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .draw_texture  (draw_texture),
    .first_vertex  (first_vertex),
    .vertex_total  (vertex_total),
    .last_result   (last_result),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data)
  );

  // Tracker state mirrored in the testbench
  logic [TW-1:0] m_default_tex;
  logic          m_pipe_ready;
  logic [CW-1:0] vert_fill;
  int            ranges_used;
  logic          range_live;
  logic [TW-1:0] cur_tex;
  logic [TW-1:0] range_tex   [MAX_RANGES];
  logic [CW-1:0] range_first [MAX_RANGES];
  logic [CW-1:0] range_len   [MAX_RANGES];

  result_t request_results[$];
  result_t pending_records[$];
  row_t    directed_rows[$];

  check_t        cur_chk  = CHK_MODEL;
  result_t       cur_exp  = '0;
  logic          idle_off = 1'b0;
  logic [TW-1:0] last_tex = '0;

  int stall_cycles = 0;
  int n_items      = 0;
  int n_results    = 0;
  int n_draws      = 0;
  int n_grants     = 0;
  int n_errors     = 0;
  int n_cfg        = 0;
  int n_fills      = 0;

  function automatic result_t grant(input int slot);
    return '{dbrt_pkg::KIND_GRANT, TW'(0), CW'(slot), CW'(0), 1'b1};
  endfunction

  function automatic result_t draw(input logic [TW-1:0] t, input int first,
                                   input int total, input logic last);
    return '{dbrt_pkg::KIND_DRAW, t, CW'(first), CW'(total), last};
  endfunction

  function automatic void close_open_range();
    if (range_live && ranges_used >= 1) begin
      range_len[ranges_used-1] = vert_fill - range_first[ranges_used-1];
      range_live = 1'b0;
    end
  endfunction

  function automatic void open_range(input logic [TW-1:0] t);
    if (ranges_used < MAX_RANGES) begin
      range_tex[ranges_used]   = t;
      range_first[ranges_used] = vert_fill;
      range_len[ranges_used]   = '0;
      ranges_used++;
      cur_tex    = t;
      range_live = 1'b1;
    end
  endfunction

  // Update the mirrored state for one request and collect the beats it should produce
  function automatic void track_request(input dbrt_pkg::req_t req, input logic [TW-1:0] tex);
    int i;
    request_results.delete();
    case (req)
      dbrt_pkg::REQ_BEGIN: begin
        vert_fill   = '0;
        ranges_used = 0;
        range_live  = 1'b0;
        cur_tex     = m_default_tex;
      end
      dbrt_pkg::REQ_SET_TEX: begin
        if (!range_live) cur_tex = tex;
        else if (tex != cur_tex) begin
          close_open_range();
          open_range(tex);
        end
      end
      dbrt_pkg::REQ_PUSH: begin
        if (vert_fill < MAX_VERTICES) begin
          if (!range_live) open_range(cur_tex != '0 ? cur_tex : m_default_tex);
          request_results.push_back(grant(vert_fill));
          vert_fill++;
        end
      end
      default: begin
        if (m_pipe_ready && vert_fill != '0) begin
          close_open_range();
          if (ranges_used < 1) begin
            request_results.push_back(draw(m_default_tex, 0, vert_fill, 1'b1));
          end else begin
            for (i = 0; i < ranges_used; i++)
              if (range_len[i] != '0)
                request_results.push_back(
                  draw(range_tex[i] != '0 ? range_tex[i] : m_default_tex,
                       range_first[i], range_len[i], 1'b0));
            if (request_results.size() > 0)
              request_results[request_results.size()-1].last = 1'b1;
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Predict on accepted requests, compare accepted results, watch for a hang
  always @(posedge clk) begin
    result_t want;
    stall_cycles++;
    if (!rst && in_valid && in_ready) begin
      stall_cycles = 0;
      n_items++;
      track_request(dbrt_pkg::req_t'(req_type), texture_handle);
      case (cur_chk)
        CHK_MODEL: foreach (request_results[k]) pending_records.push_back(request_results[k]);
        CHK_ONE:   pending_records.push_back(cur_exp);
        default: ;
      endcase
    end
    if (!rst && out_valid && out_ready) begin
      stall_cycles = 0;
      n_results++;
      if (result_kind == dbrt_pkg::KIND_DRAW) n_draws++;
      else n_grants++;
      if (pending_records.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beat, expected none, actual %0d/%0d/%0d/%0d/%0d",
                 $time, result_kind, draw_texture, first_vertex, vertex_total, last_result);
      end else begin
        want = pending_records.pop_front();
        check_field("result_kind",  want.kind,  result_kind);
        check_field("draw_texture", want.tex,   draw_texture);
        check_field("first_vertex", want.first, first_vertex);
        check_field("vertex_total", want.total, vertex_total);
        check_field("last_result",  want.last,  last_result);
      end
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_records.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stall ahead of every beat
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_off ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send(input dbrt_pkg::req_t req, input logic [TW-1:0] tex,
                      input check_t chk = CHK_MODEL, input result_t exp = '0);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    req_type       = req;
    texture_handle = tex;
    cur_chk        = chk;
    cur_exp        = exp;
    if (req == dbrt_pkg::REQ_SET_TEX) last_tex = tex;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the input until every result is out, then let a silent flush walk finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IW-1:0] idx, input logic [TW-1:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == dbrt_pkg::REG_DEFAULT_TEX) m_default_tex = val;
    else m_pipe_ready = val[0];
    n_cfg++;
  endtask

  task automatic add_req(input dbrt_pkg::req_t req, input logic [TW-1:0] tex,
                         input check_t chk, input result_t exp = '0);
    directed_rows.push_back('{ROW_REQ, req, dbrt_pkg::REG_DEFAULT_TEX, tex, chk, exp});
  endtask

  task automatic add_cfg(input logic [IW-1:0] idx, input logic [TW-1:0] val);
    directed_rows.push_back('{ROW_CFG, dbrt_pkg::REQ_BEGIN, idx, val, CHK_NONE,
                              result_t'('0)});
  endtask

  function automatic logic [TW-1:0] pick_tex();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return last_tex;
      default: return TW'($urandom);
    endcase
  endfunction

  // Drive more texture changes than the range table holds, then flush
  task automatic overflow_ranges();
    int k;
    int n;
    wait_idle();
    cfg_write(dbrt_pkg::REG_PIPE_READY, TW'(1));
    idle_off = 1'b1;
    send(dbrt_pkg::REQ_BEGIN, TW'($urandom));
    for (k = 1; k <= MAX_RANGES + 1; k++) begin
      n = $urandom_range(1, 3);
      repeat (n) send(dbrt_pkg::REQ_PUSH, TW'($urandom));
      send(dbrt_pkg::REQ_SET_TEX, {k[5:0], 10'($urandom)});
    end
    send(dbrt_pkg::REQ_PUSH, TW'($urandom));
    send(dbrt_pkg::REQ_FLUSH, TW'($urandom));
    idle_off = 1'b0;
    n_fills++;
  endtask

  task automatic random_batch();
    int steps;
    int s;
    idle_off = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 3) != 0) send(dbrt_pkg::REQ_BEGIN, TW'($urandom));
      steps = $urandom_range(3, 20);
      for (s = 0; s < steps; s++)
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: repeat ($urandom_range(1, 4)) send(dbrt_pkg::REQ_PUSH, TW'($urandom));
          6, 7, 8:          send(dbrt_pkg::REQ_SET_TEX, pick_tex());
          default:          send(dbrt_pkg::REQ_FLUSH, TW'($urandom));
        endcase
      send(dbrt_pkg::REQ_FLUSH, TW'($urandom));
    end else begin
      repeat ($urandom_range(5, 15))
        send(dbrt_pkg::req_t'($urandom_range(0, 3)), TW'($urandom));
    end
    idle_off = 1'b0;
  endtask

  initial begin
    int batches;
    int start;
    m_default_tex = '0;
    m_pipe_ready  = 1'b0;
    vert_fill     = '0;
    ranges_used   = 0;
    range_live    = 1'b0;
    cur_tex       = '0;
    foreach (range_tex[i]) begin
      range_tex[i]   = '0;
      range_first[i] = '0;
      range_len[i]   = '0;
    end

    // first push after reset opens a range with texture zero
    add_req(dbrt_pkg::REQ_PUSH,    16'hFFFF, CHK_ONE, grant(0));
    add_req(dbrt_pkg::REQ_FLUSH,   16'h0000, CHK_NONE);
    add_cfg(dbrt_pkg::REG_PIPE_READY,  16'h0001);
    add_cfg(dbrt_pkg::REG_DEFAULT_TEX, 16'hFFFF);
    add_req(dbrt_pkg::REQ_FLUSH,   16'h0000, CHK_ONE, draw(16'hFFFF, 0, 1, 1'b1));
    add_req(dbrt_pkg::REQ_FLUSH,   16'hFFFF, CHK_MODEL);
    add_req(dbrt_pkg::REQ_BEGIN,   16'hAAAA, CHK_NONE);
    add_req(dbrt_pkg::REQ_FLUSH,   16'h5555, CHK_NONE);
    add_req(dbrt_pkg::REQ_SET_TEX, 16'h1234, CHK_NONE);
    add_req(dbrt_pkg::REQ_PUSH,    16'h0000, CHK_ONE, grant(0));
    add_req(dbrt_pkg::REQ_SET_TEX, 16'h1234, CHK_NONE);
    add_req(dbrt_pkg::REQ_SET_TEX, 16'h0000, CHK_NONE);
    add_req(dbrt_pkg::REQ_PUSH,    16'hFFFF, CHK_ONE, grant(1));
    add_req(dbrt_pkg::REQ_SET_TEX, 16'hFFFF, CHK_NONE);
    add_req(dbrt_pkg::REQ_SET_TEX, 16'h5555, CHK_NONE);
    add_req(dbrt_pkg::REQ_PUSH,    16'h0000, CHK_ONE, grant(2));
    add_req(dbrt_pkg::REQ_PUSH,    16'h0000, CHK_ONE, grant(3));
    add_req(dbrt_pkg::REQ_FLUSH,   16'h0000, CHK_MODEL);
    add_cfg(dbrt_pkg::REG_DEFAULT_TEX, 16'h0000);
    add_req(dbrt_pkg::REQ_BEGIN,   16'hFFFF, CHK_NONE);
    add_req(dbrt_pkg::REQ_PUSH,    16'h0000, CHK_ONE, grant(0));
    add_req(dbrt_pkg::REQ_FLUSH,   16'h0000, CHK_ONE, draw(16'h0000, 0, 1, 1'b1));
    add_cfg(dbrt_pkg::REG_PIPE_READY,  16'h0000);
    add_req(dbrt_pkg::REQ_FLUSH,   16'h0000, CHK_NONE);
    add_req(dbrt_pkg::REQ_SET_TEX, 16'hFFFF, CHK_NONE);
    add_req(dbrt_pkg::REQ_PUSH,    16'h0000, CHK_MODEL);
    add_cfg(dbrt_pkg::REG_PIPE_READY,  16'h0001);
    add_req(dbrt_pkg::REQ_FLUSH,   16'hFFFF, CHK_MODEL);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(directed_rows[r].reg_idx, directed_rows[r].data);
      end else begin
        send(directed_rows[r].req, directed_rows[r].data, directed_rows[r].chk,
             directed_rows[r].exp);
      end
    end
    wait_idle();

    batches = 0;
    start   = n_items;
    while (n_items - start < RANDOM_ITEMS) begin
      if (batches % 4 == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0:       cfg_write(dbrt_pkg::REG_DEFAULT_TEX, '0);
          1:       cfg_write(dbrt_pkg::REG_DEFAULT_TEX, '1);
          default: cfg_write(dbrt_pkg::REG_DEFAULT_TEX, TW'($urandom));
        endcase
        cfg_write(dbrt_pkg::REG_PIPE_READY, TW'($urandom_range(0, 4) != 0));
      end else if ($urandom_range(0, 5) == 0) begin
        wait_idle();
      end
      if (batches == 4) overflow_ranges();
      random_batch();
      batches++;
    end
    wait_idle();

    $display("Sent %0d requests, got %0d results (%0d draws, %0d grants), %0d register writes.",
             n_items, n_results, n_draws, n_grants, n_cfg);
    $display("Range table overflow passes: %0d, mismatches: %0d.", n_fills, n_errors);
    if (n_errors == 0 && pending_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
